### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the score sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/tss_pkg.sv
// ---------------------------------------------------------------------------
// tss_pkg
// Types, codes and constants shared by the score sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  // Default sizes
  localparam int SCORE_DEPTH_DEF = 4096;
  localparam int CHANNELS_DEF    = 8;
  localparam int MAX_EVENTS_DEF  = 16;

  // Hard caps per tick
  localparam int RESULT_CAP = 16;
  localparam int CMD_BUDGET = 256;
  localparam int CMD_CNT_W  = $clog2(CMD_BUDGET + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int LOAD_ADDR_W = 12;
  localparam int NOTE_W      = 7;
  localparam int CHAN_W      = 4;
  localparam int WAIT_W      = 15;

  // Input action codes
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Score byte codes
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [7:0] BYTE_STOP       = 8'hF0;
  localparam logic [7:0] BYTE_REWIND     = 8'hE0;

  // Classified command kinds
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TICK,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [LOAD_ADDR_W-1:0] addr;
    logic [7:0]             data;
  } cmd_t;

  // Result event kinds
  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_STOPPED  = 2'd2
  } ev_kind_t;

  // Player sequencer states
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_LOOP,
    PS_CMD,
    PS_WAIT_LO,
    PS_NOTE,
    PS_EVENT,
    PS_FLUSH
  } ps_state_t;

endpackage

`default_nettype wire

### hw/rtl/tss_front.sv
// ---------------------------------------------------------------------------
// tss_front
// Accepts input transactions, classifies them and forwards commands.
// ---------------------------------------------------------------------------
`default_nettype none

module tss_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [23:0]   in_tdata,   // [11:0] load_address, [19:12] load_byte
  input  wire logic [1:0]    in_tuser,   // [1:0] action
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output tss_pkg::cmd_t      cmd
);

  import tss_pkg::*;

  logic      f_valid_r, f_valid_nxt;
  cmd_t      f_cmd_r, f_cmd_nxt;
  logic      take;
  logic      known;
  cmd_kind_t kind;

  // Decode the action; unused code is dropped
  always_comb begin
    known = 1'b1;
    kind  = CMD_LOAD;
    unique case (in_tuser)
      ACT_LOAD:  kind = CMD_LOAD;
      ACT_TICK:  kind = CMD_TICK;
      ACT_START: kind = CMD_START;
      default:   known = 1'b0;
    endcase
  end

  assign in_tready = !f_valid_r || cmd_ready;
  assign take      = in_tvalid && in_tready;

  // Holding register toward the queue
  always_comb begin
    f_valid_nxt = f_valid_r;
    f_cmd_nxt   = f_cmd_r;
    if (f_valid_r && cmd_ready) begin
      f_valid_nxt = 1'b0;
    end
    if (take && known) begin
      f_valid_nxt    = 1'b1;
      f_cmd_nxt.kind = kind;
      f_cmd_nxt.addr = in_tdata[11:0];
      f_cmd_nxt.data = in_tdata[19:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_cmd_r <= f_cmd_nxt;
  end

  assign cmd_valid = f_valid_r;
  assign cmd       = f_cmd_r;

endmodule

`default_nettype wire

### hw/rtl/tss_fifo.sv
// ---------------------------------------------------------------------------
// tss_fifo
// Short command queue decoupling the front end from the player.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tss_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire tss_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop,
  output tss_pkg::cmd_t      pop_cmd
);

  import tss_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] cnt_r;
  logic                do_push, do_pop;

  assign push_ready = (cnt_r != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = entry_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_r <= QUEUE_CW'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_CLK(a_pop_nonempty, clk, rst_n, pop |-> (cnt_r != '0), "pop from empty queue")
  `ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1,
               "fill count missed a push")

endmodule

`default_nettype wire

### hw/rtl/tss_player.sv
// ---------------------------------------------------------------------------
// tss_player
// Score memory, command parser and event output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tss_player #(
  parameter int SCORE_DEPTH = tss_pkg::SCORE_DEPTH_DEF,
  parameter int CHANNELS    = tss_pkg::CHANNELS_DEF,
  parameter int MAX_EVENTS  = tss_pkg::MAX_EVENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire tss_pkg::cmd_t      q_cmd,
  output logic                    evt_valid,
  input  wire logic               evt_ready,
  output tss_pkg::ev_kind_t       evt_kind,
  output logic [3:0]              evt_channel,
  output logic [6:0]              evt_note,
  output logic                    evt_last
);

  import tss_pkg::*;

  localparam int AW        = $clog2(SCORE_DEPTH);
  localparam int EV_LIMIT  = (MAX_EVENTS < RESULT_CAP) ? MAX_EVENTS : RESULT_CAP;
  localparam int EV_CNT_W  = $clog2(EV_LIMIT + 1);

  // Score memory
  logic [7:0]    mem [SCORE_DEPTH];
  logic [7:0]    rdata_r;
  logic          rd_en, mem_we;

  // Control state
  ps_state_t             state_r, state_nxt;
  logic [AW-1:0]         rp_r, rp_nxt, rp_adv;
  logic [WAIT_W-1:0]     wait_r, wait_nxt, wait_dec;
  logic                  playing_r, playing_nxt;
  logic [EV_CNT_W-1:0]   ev_cnt_r, ev_cnt_nxt;
  logic [CMD_CNT_W-1:0]  cmd_cnt_r, cmd_cnt_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Payload
  logic [7:0]        cmd_r, cmd_nxt;
  ev_kind_t          new_kind_r, new_kind_nxt;
  logic [CHAN_W-1:0] new_ch_r, new_ch_nxt;
  logic [NOTE_W-1:0] new_note_r, new_note_nxt;
  ev_kind_t          pend_kind_r, pend_kind_nxt;
  logic [CHAN_W-1:0] pend_ch_r, pend_ch_nxt;
  logic [NOTE_W-1:0] pend_note_r, pend_note_nxt;
  ev_kind_t          out_kind_r, out_kind_nxt;
  logic [CHAN_W-1:0] out_ch_r, out_ch_nxt;
  logic [NOTE_W-1:0] out_note_r, out_note_nxt;
  logic              out_last_r, out_last_nxt;

  logic slot_free, push, push_last, addr_ok;

  function automatic logic chan_ok(input logic [3:0] ch);
    chan_ok = ({1'b0, ch} < 5'(CHANNELS));
  endfunction

  assign slot_free = !out_valid_r || evt_ready;
  assign rp_adv    = (rp_r == AW'(SCORE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wait_dec  = (wait_r == '0) ? '0 : wait_r - 1'b1;
  assign addr_ok   = (32'(q_cmd.addr) < SCORE_DEPTH);

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_cmd.addr)] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rp_r];
    end
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    wait_nxt       = wait_r;
    playing_nxt    = playing_r;
    ev_cnt_nxt     = ev_cnt_r;
    cmd_cnt_nxt    = cmd_cnt_r;
    pend_valid_nxt = pend_valid_r;
    cmd_nxt        = cmd_r;
    new_kind_nxt   = new_kind_r;
    new_ch_nxt     = new_ch_r;
    new_note_nxt   = new_note_r;
    pend_kind_nxt  = pend_kind_r;
    pend_ch_nxt    = pend_ch_r;
    pend_note_nxt  = pend_note_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;

    unique case (state_r)
      PS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_LOAD: begin
              mem_we = addr_ok;
            end
            CMD_START: begin
              rp_nxt      = '0;
              wait_nxt    = '0;
              playing_nxt = 1'b1;
            end
            CMD_TICK: begin
              if (playing_r) begin
                wait_nxt = wait_dec;
                if (wait_dec == '0) begin
                  ev_cnt_nxt  = '0;
                  cmd_cnt_nxt = '0;
                  state_nxt   = PS_LOOP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Parse another command while budget and wait allow
      PS_LOOP: begin
        if (playing_r && (wait_r == '0) && (ev_cnt_r < EV_CNT_W'(EV_LIMIT)) &&
            (cmd_cnt_r < CMD_CNT_W'(CMD_BUDGET))) begin
          rd_en       = 1'b1;
          rp_nxt      = rp_adv;
          cmd_cnt_nxt = cmd_cnt_r + 1'b1;
          state_nxt   = PS_CMD;
        end else begin
          state_nxt = PS_FLUSH;
        end
      end

      // Decode the command byte
      PS_CMD: begin
        cmd_nxt = rdata_r;
        if (!rdata_r[7]) begin
          rd_en     = 1'b1;
          rp_nxt    = rp_adv;
          state_nxt = PS_WAIT_LO;
        end else if (rdata_r[7:4] == STATUS_NOTE_ON) begin
          rd_en     = 1'b1;
          rp_nxt    = rp_adv;
          state_nxt = PS_NOTE;
        end else if (rdata_r[7:4] == STATUS_NOTE_OFF) begin
          if (chan_ok(rdata_r[3:0])) begin
            new_kind_nxt = EV_NOTE_OFF;
            new_ch_nxt   = rdata_r[3:0];
            new_note_nxt = '0;
            state_nxt    = PS_EVENT;
          end else begin
            state_nxt = PS_LOOP;
          end
        end else if (rdata_r == BYTE_STOP) begin
          new_kind_nxt = EV_STOPPED;
          new_ch_nxt   = '0;
          new_note_nxt = '0;
          playing_nxt  = 1'b0;
          state_nxt    = PS_EVENT;
        end else if (rdata_r == BYTE_REWIND) begin
          rp_nxt    = '0;
          state_nxt = PS_LOOP;
        end else begin
          state_nxt = PS_LOOP;
        end
      end

      // Low byte of a wait
      PS_WAIT_LO: begin
        wait_nxt  = {cmd_r[6:0], rdata_r};
        state_nxt = PS_LOOP;
      end

      // Note byte of a note-on
      PS_NOTE: begin
        if (chan_ok(cmd_r[3:0])) begin
          new_kind_nxt = EV_NOTE_ON;
          new_ch_nxt   = cmd_r[3:0];
          new_note_nxt = rdata_r[7] ? '0 : rdata_r[6:0];
          state_nxt    = PS_EVENT;
        end else begin
          state_nxt = PS_LOOP;
        end
      end

      // Hold one event back so the final one can carry last
      PS_EVENT: begin
        if (!pend_valid_r || slot_free) begin
          push           = pend_valid_r;
          pend_valid_nxt = 1'b1;
          pend_kind_nxt  = new_kind_r;
          pend_ch_nxt    = new_ch_r;
          pend_note_nxt  = new_note_r;
          ev_cnt_nxt     = ev_cnt_r + 1'b1;
          state_nxt      = PS_LOOP;
        end
      end

      // End of tick: release the held event as last
      PS_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = PS_IDLE;
        end else if (slot_free) begin
          push           = 1'b1;
          push_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = PS_IDLE;
        end
      end

      default: state_nxt = PS_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_ch_nxt    = out_ch_r;
    out_note_nxt  = out_note_r;
    out_last_nxt  = out_last_r;
    if (evt_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pend_kind_r;
      out_ch_nxt    = pend_ch_r;
      out_note_nxt  = pend_note_r;
      out_last_nxt  = push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PS_IDLE;
      rp_r         <= '0;
      wait_r       <= '0;
      playing_r    <= 1'b0;
      ev_cnt_r     <= '0;
      cmd_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      wait_r       <= wait_nxt;
      playing_r    <= playing_nxt;
      ev_cnt_r     <= ev_cnt_nxt;
      cmd_cnt_r    <= cmd_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    new_kind_r  <= new_kind_nxt;
    new_ch_r    <= new_ch_nxt;
    new_note_r  <= new_note_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_ch_r   <= pend_ch_nxt;
    pend_note_r <= pend_note_nxt;
    out_kind_r  <= out_kind_nxt;
    out_ch_r    <= out_ch_nxt;
    out_note_r  <= out_note_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign evt_valid   = out_valid_r;
  assign evt_kind    = out_kind_r;
  assign evt_channel = out_ch_r;
  assign evt_note    = out_note_r;
  assign evt_last    = out_last_r;

  `ASSERT_CLK(a_ev_bound, clk, rst_n, ev_cnt_r <= EV_CNT_W'(EV_LIMIT), "event count over limit")
  `ASSERT_CLK(a_rp_range, clk, rst_n, 32'(rp_r) < SCORE_DEPTH, "read pointer out of range")
  `ASSERT_CLK(a_idle_nopend, clk, rst_n, (state_r == PS_IDLE) |-> !pend_valid_r,
              "event held while idle")
  `ASSERT_NEXT(a_stop_halts, clk, rst_n, (state_r == PS_CMD) && (rdata_r == BYTE_STOP),
               !playing_r, "stop did not halt play")

endmodule

`default_nettype wire

### hw/rtl/tune_score_sequencer.sv
// A load or start transaction reaches the player via the front register and the queue.
// Ticks that only count down keep the player idle; throughput is then 1 transaction/cycle.
// Parsing runs PS_LOOP, PS_CMD per command, plus PS_WAIT_LO (wait), PS_NOTE (note-on),
// PS_EVENT per event, as the score memory has a single registered read port.
// Reset clears pointer, wait, play flag, queue and output; score memory is not cleared.
// ---------------------------------------------------------------------------
// tune_score_sequencer
// Byte-score player: front end classifies transactions, a queue decouples,
// the player parses the score on millisecond ticks and emits note events.
// ---------------------------------------------------------------------------
`default_nettype none

module tune_score_sequencer #(
  parameter int SCORE_DEPTH = tss_pkg::SCORE_DEPTH_DEF,
  parameter int CHANNELS    = tss_pkg::CHANNELS_DEF,
  parameter int MAX_EVENTS  = tss_pkg::MAX_EVENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [11:0] load_address, [19:12] load_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [3:0] event_channel, [10:4] event_note
  output logic [1:0]       out_tuser,  // [1:0] event_kind
  output logic             out_tlast   // last
);

  import tss_pkg::*;

  logic     f_valid, f_ready;
  cmd_t     f_cmd;
  logic     q_valid, q_pop;
  cmd_t     q_cmd;
  ev_kind_t evt_kind;
  logic [3:0] evt_channel;
  logic [6:0] evt_note;

  tss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  tss_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  tss_player #(
    .SCORE_DEPTH (SCORE_DEPTH),
    .CHANNELS    (CHANNELS),
    .MAX_EVENTS  (MAX_EVENTS)
  ) u_player (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .evt_valid   (out_tvalid),
    .evt_ready   (out_tready),
    .evt_kind    (evt_kind),
    .evt_channel (evt_channel),
    .evt_note    (evt_note),
    .evt_last    (out_tlast)
  );

  // Pack result fields
  assign out_tdata = {5'd0, evt_note, evt_channel};
  assign out_tuser = evt_kind;

endmodule

`default_nettype wire

### sim/score_event_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// score_event_checker
// Watches both stream channels of the score sequencer, replays every input
// transaction on its own copy of the score player and compares each note
// event that leaves the block with the oldest predicted event.
// ---------------------------------------------------------------------------

module score_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] load_address, [19:12] load_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [3:0] event_channel, [10:4] event_note
  input  logic [1:0]  out_tuser,  // [1:0] event_kind
  input  logic        out_tlast,  // last
  output int          mismatch_count,
  output int          events_pending
);

  import tss_pkg::*;

  localparam int EVENT_LIMIT = (MAX_EVENTS_DEF < RESULT_CAP) ? MAX_EVENTS_DEF : RESULT_CAP;

  typedef struct packed {
    ev_kind_t          kind;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] note;
    logic              last;
  } note_event_t;

  // Shadow of the player
  logic [7:0]             score_mem [SCORE_DEPTH_DEF];
  logic [LOAD_ADDR_W-1:0] play_ptr;
  logic [WAIT_W-1:0]      wait_left;
  logic                   playing;

  note_event_t predicted_events[$];

  initial mismatch_count = 0;
  initial events_pending = 0;

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Next score byte; the pointer wraps at the end of memory
  function automatic logic [7:0] next_score_byte();
    logic [7:0] b;
    b = score_mem[play_ptr];
    play_ptr = play_ptr + 1'b1;
    return b;
  endfunction

  // Apply one input transaction and queue the events a tick produces
  function automatic void play_txn(input logic [1:0] act, input logic [LOAD_ADDR_W-1:0] addr,
                                   input logic [7:0] data);
    logic [7:0]  cmd_byte;
    logic [7:0]  arg_byte;
    int          n_cmd;
    note_event_t ev;
    note_event_t tick_events[$];
    n_cmd = 0;
    ev = '0;
    case (act)
      ACT_LOAD: begin
        score_mem[addr] = data;
      end
      ACT_START: begin
        play_ptr  = '0;
        wait_left = '0;
        playing   = 1'b1;
      end
      ACT_TICK: begin
        if (playing) begin
          if (wait_left != '0) wait_left = wait_left - 1'b1;
          // parse until a wait, a stop, the event cap or the command budget
          while (playing && wait_left == '0 && tick_events.size() < EVENT_LIMIT &&
                 n_cmd < CMD_BUDGET) begin
            cmd_byte = next_score_byte();
            n_cmd++;
            ev = '0;
            if (!cmd_byte[7]) begin
              arg_byte  = next_score_byte();
              wait_left = {cmd_byte[6:0], arg_byte};
            end else if (cmd_byte[7:4] == STATUS_NOTE_ON) begin
              arg_byte = next_score_byte();
              if (cmd_byte[3:0] < CHANNELS_DEF) begin
                ev.kind = EV_NOTE_ON;
                ev.chan = cmd_byte[3:0];
                ev.note = arg_byte[7] ? '0 : arg_byte[6:0];
                tick_events.push_back(ev);
              end
            end else if (cmd_byte[7:4] == STATUS_NOTE_OFF) begin
              if (cmd_byte[3:0] < CHANNELS_DEF) begin
                ev.kind = EV_NOTE_OFF;
                ev.chan = cmd_byte[3:0];
                tick_events.push_back(ev);
              end
            end else if (cmd_byte == BYTE_STOP) begin
              ev.kind = EV_STOPPED;
              tick_events.push_back(ev);
              playing = 1'b0;
            end else if (cmd_byte == BYTE_REWIND) begin
              play_ptr = '0;
            end
          end
          // final event of the tick carries last
          while (tick_events.size() > 0) begin
            ev = tick_events.pop_front();
            ev.last = (tick_events.size() == 0);
            predicted_events.push_back(ev);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic check_event();
    note_event_t want;
    if (predicted_events.size() == 0) begin
      flag_mismatch($sformatf("unexpected event kind=%0d ch=%0d note=%0d last=%0b",
                              out_tuser, out_tdata[3:0], out_tdata[10:4], out_tlast));
    end else begin
      want = predicted_events.pop_front();
      if (out_tuser != want.kind)
        flag_mismatch($sformatf("event_kind %0d, want %0d", out_tuser, want.kind));
      if (out_tdata[3:0] != want.chan)
        flag_mismatch($sformatf("event_channel %0d, want %0d", out_tdata[3:0], want.chan));
      if (out_tdata[10:4] != want.note)
        flag_mismatch($sformatf("event_note %0d, want %0d", out_tdata[10:4], want.note));
      if (out_tlast != want.last)
        flag_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
    end
  endtask

  // Results are checked before the same edge's input is applied
  always @(posedge clk) begin
    if (!rst_n) begin
      play_ptr  = '0;
      wait_left = '0;
      playing   = 1'b0;
      predicted_events.delete();
    end else begin
      if (out_tvalid && out_tready) check_event();
      if (in_tvalid && in_tready) play_txn(in_tuser, in_tdata[11:0], in_tdata[19:12]);
    end
    events_pending <= predicted_events.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Score sequencer testbench: loads scores, starts play and sends ticks with
// random gaps and output stalls; the checker predicts and compares events.
// ---------------------------------------------------------------------------

module tb_top;
  import tss_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 400;
  localparam int         REGION_END   = 30;    // scores live below this address
  localparam int         REGION_FILL  = 32;    // bytes 30 and 31 always hold stop
  localparam int         IDLE_LIMIT   = 20000;
  localparam int         DRAIN_CYCLES = 4000;

  typedef enum int {
    SCENE_MIXED,
    SCENE_FLOOD,
    SCENE_SPIN,
    SCENE_LONG_WAIT
  } scene_kind_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [11:0] load_address, [19:12] load_byte
  logic [1:0]  in_tuser   = '0;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [3:0] event_channel, [10:4] event_note
  logic [1:0]  out_tuser;         // [1:0] event_kind
  logic        out_tlast;         // last

  int mismatch_count;
  int events_pending;
  int send_idle_pct = 31;
  int recv_idle_pct = 45;
  int items_sent    = 0;
  int idle_cycles   = 0;

  logic [7:0] score_buf[$];

  always #5 clk = ~clk;

  tune_score_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  score_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .events_pending (events_pending)
  );

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One input transaction, with random gaps ahead of it
  task automatic send_txn(input logic [1:0] act, input logic [11:0] addr,
                          input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'h0, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_score();
    int i;
    for (i = 0; i < score_buf.size(); i++) send_txn(ACT_LOAD, 12'(i), score_buf[i]);
  endtask

  // Stray transactions: unused action, far loads, score overwrites, restarts
  task automatic send_noise();
    case ($urandom_range(3))
      0: send_txn(ACT_UNUSED, 12'($urandom), 8'($urandom));
      1: send_txn(ACT_LOAD, 12'($urandom_range(4095, REGION_FILL)), 8'($urandom));
      2: send_txn(ACT_LOAD, 12'($urandom_range(REGION_END - 1, 0)), 8'($urandom));
      default: send_txn(ACT_START, 12'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic send_ticks(input int n, input bit noisy);
    int i;
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(99) < 6) send_noise();
      send_txn(ACT_TICK, 12'($urandom), 8'($urandom));
    end
  endtask

  // Random well-formed score ending in stop or rewind
  task automatic build_mixed(output int wait_sum);
    int         room;
    int         pick;
    logic [3:0] ch;
    logic [7:0] lo;
    score_buf.delete();
    wait_sum = 0;
    room = $urandom_range(REGION_END - 1, 4);
    while (room > 2) begin
      pick = $urandom_range(99);
      ch   = 4'($urandom);
      if (pick < 25) begin
        lo = 8'($urandom_range(4));
        score_buf.push_back(8'h00);
        score_buf.push_back(lo);
        wait_sum += lo;
        room -= 2;
      end else if (pick < 50) begin
        score_buf.push_back({STATUS_NOTE_ON, ch});
        score_buf.push_back(8'($urandom));
        room -= 2;
      end else if (pick < 75) begin
        score_buf.push_back({STATUS_NOTE_OFF, ch});
        room -= 1;
      end else begin
        // bytes with no effect
        case ($urandom_range(2))
          0: score_buf.push_back(8'($urandom_range(8'hDF, 8'hA0)));
          1: score_buf.push_back({BYTE_REWIND[7:4], 4'($urandom_range(15, 1))});
          default: score_buf.push_back({BYTE_STOP[7:4], 4'($urandom_range(15, 1))});
        endcase
        room -= 1;
      end
    end
    score_buf.push_back(($urandom_range(3) == 0) ? BYTE_REWIND : BYTE_STOP);
  endtask

  task automatic play_scene(input scene_kind_t kind);
    int wait_sum;
    int n;
    int i;
    score_buf.delete();
    case (kind)
      SCENE_MIXED: begin
        build_mixed(wait_sum);
        load_score();
        send_txn(ACT_START, '0, '0);
        send_ticks(wait_sum + 4 + $urandom_range(3), 1'b1);
      end
      SCENE_FLOOD: begin
        // more events than one tick may give
        n = $urandom_range(REGION_END - 2, 17);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(1)) score_buf.push_back({STATUS_NOTE_OFF, 1'b0, 3'($urandom)});
          else score_buf.push_back({STATUS_NOTE_ON, 1'b0, 3'($urandom)});
        end
        score_buf.push_back(BYTE_STOP);
        load_score();
        send_txn(ACT_START, '0, '0);
        send_ticks(3, 1'b0);
      end
      SCENE_SPIN: begin
        // endless zero-wait or rewind loop, bounded by the command budget
        if ($urandom_range(1)) begin
          score_buf.push_back(8'h00);
          score_buf.push_back(8'h00);
        end
        score_buf.push_back(BYTE_REWIND);
        load_score();
        send_txn(ACT_START, '0, '0);
        send_ticks($urandom_range(4, 2), 1'b0);
      end
      default: begin
        // long wait cut short by a restart
        score_buf.push_back({STATUS_NOTE_ON, 4'($urandom_range(7))});
        score_buf.push_back(8'($urandom));
        score_buf.push_back(8'($urandom_range(127, 1)));
        score_buf.push_back(8'($urandom));
        score_buf.push_back({STATUS_NOTE_OFF, 4'($urandom_range(7))});
        score_buf.push_back(BYTE_STOP);
        load_score();
        send_txn(ACT_START, '0, '0);
        send_ticks($urandom_range(6, 3), 1'b0);
        send_txn(ACT_START, '0, '0);
        send_ticks(1, 1'b0);
      end
    endcase
  endtask

  initial begin
    int          i;
    int          start_count;
    int          scene_idx;
    int          phase;
    scene_kind_t kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the score region with stops so no unwritten byte is ever read
    for (i = 0; i < REGION_FILL; i++) send_txn(ACT_LOAD, 12'(i), BYTE_STOP);

    // Tick while stopped, then the unused action
    send_txn(ACT_TICK, '0, '0);
    send_txn(ACT_UNUSED, 12'hFFF, 8'hFF);

    // Directed score: note-on, dropped channel, note above 127, note-off,
    // a no-effect byte, a two-tick wait, a note-off, then stop
    score_buf = '{{STATUS_NOTE_ON, 4'h0}, 8'h3C, {STATUS_NOTE_ON, 4'hF}, 8'h10,
                  {STATUS_NOTE_ON, 4'h7}, 8'hFF, {STATUS_NOTE_OFF, 4'h1},
                  {STATUS_NOTE_OFF, 4'hF}, 8'hA5, 8'h00, 8'h02,
                  {STATUS_NOTE_OFF, 4'h0}, BYTE_STOP};
    load_score();
    send_txn(ACT_START, '0, '0);
    send_ticks(4, 1'b0);

    // Random scenes, idling shifted across three phases
    start_count = items_sent;
    scene_idx   = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      phase = (items_sent - start_count) * 3 / RANDOM_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (scene_idx < 4) begin
        kind = scene_kind_t'(scene_idx);
      end else begin
        i = $urandom_range(99);
        kind = (i < 70) ? SCENE_MIXED : (i < 80) ? SCENE_FLOOD :
               (i < 90) ? SCENE_SPIN : SCENE_LONG_WAIT;
      end
      play_scene(kind);
      scene_idx++;
    end
    in_tvalid <= 1'b0;

    // Drain outstanding events, then let any busy tick finish
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
